// File: design/fwm_pkg.sv
// Shared types and constants for the frame rate window meter.
// No dependencies; imported by fwm_ms_convert and frame_rate_window_meter.
`default_nettype none

package fwm_pkg;

   // millisecond conversion: ns / 1e6 == (ns >> 6) / 15625
   localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
   localparam int          NS_SHIFT     = 6;
   localparam logic [13:0] NS_ODD_DIV   = 14'd15625;
   // floor(2^34 / 15625); estimate is exact or one short
   localparam logic [20:0] RECIP_M      = 21'd1099511;
   localparam int          RECIP_SHIFT  = 34;

   localparam logic [15:0] WINDOW_RESET = 16'd1000;
   localparam logic [7:0]  RATE_MAX     = 8'd255;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DRAIN = 4'b1000
   } fwm_state_type;

endpackage

`default_nettype wire

// File: design/fwm_ms_convert.sv
// Four-stage pipeline turning seconds and nanoseconds into a 32-bit millisecond count.
// Depends on fwm_pkg for the conversion constants.
`default_nettype none

module fwm_ms_convert
   import fwm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] sec,
   input  wire logic [29:0] nsec,
   output logic             done,
   output logic [31:0]      ms_value
);

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [31:0] secms1_ff, secms2_ff, secms3_ff;
   logic [23:0] x1_ff, x2_ff;
   logic [10:0] q01_ff, q02_ff, q3_ff;
   logic [24:0] p2_ff;
   logic [31:0] ms4_ff;

   logic [41:0] secms_full;
   logic [23:0] x_in;
   logic [44:0] recip_full;
   logic [24:0] p2_in;
   logic [23:0] rem;
   logic [10:0] q3_in;
   logic [31:0] ms4_in;

   always_comb begin
      secms_full = {10'b0, sec} * {32'b0, MS_PER_SEC};
      x_in       = nsec[29:NS_SHIFT];
      recip_full = {21'b0, x_in} * {24'b0, RECIP_M};
      p2_in      = {14'b0, q01_ff} * {11'b0, NS_ODD_DIV};
      rem        = x2_ff - p2_ff[23:0];
      // estimate may be one short of the true quotient
      q3_in      = (rem >= {10'b0, NS_ODD_DIV}) ? q02_ff + 11'd1 : q02_ff;
      ms4_in     = secms3_ff + {21'b0, q3_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      secms1_ff <= secms_full[31:0];
      x1_ff     <= x_in;
      q01_ff    <= recip_full[44:RECIP_SHIFT];
      secms2_ff <= secms1_ff;
      x2_ff     <= x1_ff;
      q02_ff    <= q01_ff;
      p2_ff     <= p2_in;
      secms3_ff <= secms2_ff;
      q3_ff     <= q3_in;
      ms4_ff    <= ms4_in;
   end

   assign done     = v4_ff;
   assign ms_value = ms4_ff;

endmodule

`default_nettype wire

// File: design/frame_rate_window_meter.sv
// One request at a time: a new request is taken only in idle, after the last
// response is loaded; the ring's single read port is walked once per item,
// one entry a cycle, behind a four-stage ms conversion.
// A response waiting in the output register does not hold off the next request.
// Reset: synchronous; window_ms = 1000, write slot 0, fill count 0 (unwritten
// ring entries read as zero, so no clearing pass is needed).
`default_nettype none

module frame_rate_window_meter
   import fwm_pkg::*;
#(
   parameter int RING_DEPTH = 200
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_stamp_seconds,
   input  wire logic [29:0] req_stamp_nanoseconds,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_frame_rate,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_window_ms
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
   localparam logic [CW-1:0] FULL_FILL = CW'(RING_DEPTH);

   fwm_state_type state_ff, state_in;

   logic [15:0]   window_ff;
   logic [AW-1:0] slot_ff, slot_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [31:0]   now_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rd_vld_ff, dif_vld_ff, mag_vld_ff;
   logic          live_ff;
   logic [31:0]   ring_q_ff, diff_ff, mag_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rate_ff;

   logic [31:0]   ring_mem [RING_DEPTH];

   logic          req_xfer, conv_done, ring_we, ring_re, load_rsp, pipe_empty;
   logic [31:0]   conv_ms, entry, mag_in;

   fwm_ms_convert u_conv (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .sec      (req_stamp_seconds),
      .nsec     (req_stamp_nanoseconds),
      .done     (conv_done),
      .ms_value (conv_ms)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign ring_we   = (state_ff == ST_CONV) && conv_done;
   assign ring_re   = (state_ff == ST_SCAN);
   assign pipe_empty = !rd_vld_ff && !dif_vld_ff && !mag_vld_ff;
   assign load_rsp  = (state_ff == ST_DRAIN) && pipe_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      fill_in  = fill_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_CONV;
         end
         ST_CONV: begin
            count_in = '0;
            addr_in  = '0;
            if (conv_done) begin
               slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
               fill_in  = (fill_ff == FULL_FILL) ? fill_ff : fill_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_SLOT) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (mag_vld_ff && (mag_ff < {16'b0, window_ff})) count_in = count_ff + 1'b1;
   end

   always_comb begin
      entry  = live_ff ? ring_q_ff : 32'd0;
      mag_in = diff_ff[31] ? (~diff_ff + 32'd1) : diff_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         slot_ff      <= '0;
         fill_ff      <= '0;
         addr_ff      <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         dif_vld_ff   <= 1'b0;
         mag_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid) window_ff <= csr_window_ms;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         rd_vld_ff    <= ring_re;
         dif_vld_ff   <= rd_vld_ff;
         mag_vld_ff   <= dif_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ring memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[slot_ff] <= conv_ms;
      if (ring_re) ring_q_ff <= ring_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (ring_we) now_ff <= conv_ms;
      // slots at or beyond the fill count were never written and read as zero
      live_ff <= CW'(addr_ff) < fill_ff;
      diff_ff <= now_ff - entry;
      mag_ff  <= mag_in;
      if (load_rsp) begin
         if (32'(count_ff) > 32'(RATE_MAX)) rate_ff <= RATE_MAX;
         else                               rate_ff <= 8'(count_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_rate = rate_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL) else $error("fill count beyond ring depth");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT) else $error("write slot beyond ring");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_FILL) else $error("count exceeds ring depth");

   a_req_to_conv: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_CONV) else $error("transfer not converted");

   a_conv_in_state: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> state_ff == ST_CONV) else $error("conversion result outside convert state");

endmodule

`default_nettype wire
